// ===== hw/rtl/catt_pkg.sv =====
`timescale 1ns / 1ps

package catt_pkg;

   localparam int unsigned ModeW    = 2;
   localparam int unsigned TimeW    = 32;
   localparam int unsigned SeqW     = 8;
   localparam int unsigned StatusW  = 2;
   localparam int unsigned TimeoutW = 20;
   localparam int unsigned CdW      = 10;

   localparam logic [ModeW-1:0] MODE_SET    = 2'd0;
   localparam logic [ModeW-1:0] MODE_REPORT = 2'd1;
   localparam logic [ModeW-1:0] MODE_TICK   = 2'd2;

   localparam logic [StatusW-1:0] STATUS_PENDING = 2'd0;
   localparam logic [StatusW-1:0] STATUS_SUCCESS = 2'd1;

   localparam logic [TimeoutW-1:0] TIMEOUT_RESET = 20'd10000;

   typedef struct packed {
      logic [ModeW-1:0]   mode;
      logic [TimeW-1:0]   now_ms;
      logic [SeqW-1:0]    remote_seq_in;
      logic [StatusW-1:0] remote_status;
   } req_item_type;

   typedef struct packed {
      logic            send_ack;
      logic            ack_success;
      logic            send_nack;
      logic            countdown_valid;
      logic [CdW-1:0]  countdown_sec;
      logic            set_rejected;
      logic            command_active;
      logic [SeqW-1:0] local_seq_out;
   } rsp_item_type;

endpackage

// ===== hw/rtl/catt_req_if.sv =====
`timescale 1ns / 1ps

interface catt_req_if;
   import catt_pkg::*;

   logic               valid;
   logic               ready;
   logic [ModeW-1:0]   mode;
   logic [TimeW-1:0]   now_ms;
   logic [SeqW-1:0]    remote_seq_in;
   logic [StatusW-1:0] remote_status;

   modport source (output valid, output mode, output now_ms, output remote_seq_in,
                   output remote_status, input ready);
   modport sink   (input valid, input mode, input now_ms, input remote_seq_in,
                   input remote_status, output ready);
endinterface

// ===== hw/rtl/catt_rsp_if.sv =====
`timescale 1ns / 1ps

interface catt_rsp_if;
   import catt_pkg::*;

   logic            valid;
   logic            ready;
   logic            send_ack;
   logic            ack_success;
   logic            send_nack;
   logic            countdown_valid;
   logic [CdW-1:0]  countdown_sec;
   logic            set_rejected;
   logic            command_active;
   logic [SeqW-1:0] local_seq_out;

   modport source (output valid, output send_ack, output ack_success, output send_nack,
                   output countdown_valid, output countdown_sec, output set_rejected,
                   output command_active, output local_seq_out, input ready);
   modport sink   (input valid, input send_ack, input ack_success, input send_nack,
                   input countdown_valid, input countdown_sec, input set_rejected,
                   input command_active, input local_seq_out, output ready);
endinterface

// ===== hw/rtl/catt_core.sv =====
`timescale 1ns / 1ps

module catt_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              step,
   input  catt_pkg::req_item_type            item,
   input  logic [catt_pkg::TimeoutW-1:0]     timeout,
   output catt_pkg::rsp_item_type            result
);
   import catt_pkg::*;

   // floor(x / 1000) == (x * ceil(2^30 / 1000)) >> 30 for every 20-bit x
   localparam int unsigned RecipShift = 30;
   localparam int unsigned RecipW     = 21;
   localparam logic [RecipW-1:0] Recip = RecipW'(((64'd1 << RecipShift) + 64'd999) / 64'd1000);
   localparam int unsigned ProdW      = TimeoutW + RecipW;
   localparam int unsigned QuotW      = ProdW - RecipShift;

   logic               active_ff, active_in;
   logic [SeqW-1:0]    local_seq_ff, local_seq_in;
   logic [SeqW-1:0]    remote_seq_ff, remote_seq_in;
   logic [TimeW-1:0]   start_time_ff, start_time_in;
   logic [CdW-1:0]     last_cd_ff, last_cd_in;

   logic [TimeW-1:0]    elapsed;
   logic                timed_out;
   logic [TimeoutW-1:0] rem_ms;
   logic [ProdW-1:0]    prod;
   logic [QuotW-1:0]    quot;
   logic [CdW-1:0]      rem_sec;

   assign elapsed   = item.now_ms - start_time_ff;
   assign timed_out = elapsed > {{(TimeW-TimeoutW){1'b0}}, timeout};
   assign rem_ms    = timeout - elapsed[TimeoutW-1:0];
   assign prod      = ProdW'(rem_ms) * ProdW'(Recip);
   assign quot      = prod[ProdW-1:RecipShift];
   assign rem_sec   = (quot > QuotW'({CdW{1'b1}})) ? {CdW{1'b1}} : quot[CdW-1:0];

   always_comb begin
      active_in     = active_ff;
      local_seq_in  = local_seq_ff;
      remote_seq_in = remote_seq_ff;
      start_time_in = start_time_ff;
      last_cd_in    = last_cd_ff;
      result        = '0;
      unique case (item.mode)
         MODE_SET: begin
            if (active_ff) begin
               result.set_rejected = 1'b1;
            end else begin
               local_seq_in  = local_seq_ff + 1'b1;
               start_time_in = item.now_ms;
               active_in     = 1'b1;
            end
         end
         MODE_REPORT: begin
            remote_seq_in = item.remote_seq_in;
            if (active_ff && (item.remote_seq_in == local_seq_ff)) begin
               if (item.remote_status != STATUS_PENDING) begin
                  active_in              = 1'b0;
                  start_time_in          = '0;
                  result.send_ack        = 1'b1;
                  result.ack_success     = (item.remote_status == STATUS_SUCCESS);
                  result.countdown_valid = 1'b1;
                  result.countdown_sec   = last_cd_ff;
               end
            end else if (!active_ff && (item.remote_seq_in != local_seq_ff)) begin
               active_in        = 1'b0;
               start_time_in    = '0;
               result.send_nack = 1'b1;
            end
         end
         MODE_TICK: begin
            if (active_ff) begin
               if (timed_out) begin
                  active_in        = 1'b0;
                  start_time_in    = '0;
                  result.send_nack = 1'b1;
               end else if (rem_sec != last_cd_ff) begin
                  last_cd_in             = rem_sec;
                  result.countdown_valid = 1'b1;
                  result.countdown_sec   = rem_sec;
               end
            end
         end
         default: begin
         end
      endcase
      result.command_active = active_in;
      result.local_seq_out  = local_seq_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff     <= 1'b0;
         local_seq_ff  <= '0;
         remote_seq_ff <= '0;
         start_time_ff <= '0;
         last_cd_ff    <= '0;
      end else if (step) begin
         active_ff     <= active_in;
         local_seq_ff  <= local_seq_in;
         remote_seq_ff <= remote_seq_in;
         start_time_ff <= start_time_in;
         last_cd_ff    <= last_cd_in;
      end
   end

endmodule

// ===== hw/rtl/command_ack_timeout_tracker_unit.sv =====
`timescale 1ns / 1ps

// Single outstanding command tracker with ACK/NACK and timeout countdown. Every request
// transfer yields exactly one response transfer, in order. A request passes through
// one input register, then the decision logic (32-bit elapsed-time subtract, timeout
// compare and a divide-by-1000 done as a 20x21-bit reciprocal multiply) feeding the
// response register. A new request is taken every cycle while the response side keeps
// up; the response register lets a request be taken while a finished response still
// waits. Write csr_wr_data (timeout in ms) only while no request is in flight.
module command_ack_timeout_tracker_unit (
   input  logic                          clock,
   input  logic                          reset,
   catt_req_if.sink                      req_chan,
   catt_rsp_if.source                    rsp_chan,
   input  logic                          csr_wr_en,
   input  logic [catt_pkg::TimeoutW-1:0] csr_wr_data
);
   import catt_pkg::*;

   logic [TimeoutW-1:0] timeout_ff;
   logic                s1_valid_ff;
   req_item_type        s1_item_ff;
   logic                rsp_valid_ff;
   rsp_item_type        rsp_item_ff;
   rsp_item_type        core_result;
   req_item_type        req_item;
   logic                advance;

   assign advance        = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || advance;

   assign req_item.mode          = req_chan.mode;
   assign req_item.now_ms        = req_chan.now_ms;
   assign req_item.remote_seq_in = req_chan.remote_seq_in;
   assign req_item.remote_status = req_chan.remote_status;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
      end else if (csr_wr_en) begin
         timeout_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         s1_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         s1_item_ff <= req_item;
      end
   end

   catt_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .item    (s1_item_ff),
      .timeout (timeout_ff),
      .result  (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_item_ff <= core_result;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.send_ack        = rsp_item_ff.send_ack;
   assign rsp_chan.ack_success     = rsp_item_ff.ack_success;
   assign rsp_chan.send_nack       = rsp_item_ff.send_nack;
   assign rsp_chan.countdown_valid = rsp_item_ff.countdown_valid;
   assign rsp_chan.countdown_sec   = rsp_item_ff.countdown_sec;
   assign rsp_chan.set_rejected    = rsp_item_ff.set_rejected;
   assign rsp_chan.command_active  = rsp_item_ff.command_active;
   assign rsp_chan.local_seq_out   = rsp_item_ff.local_seq_out;

endmodule
